// ----- rtl/tsd_pkg.sv -----
package tsd_pkg;

    // sliding window depth and lag ring depth
    localparam int WINDOW = 60;
    localparam int LAG    = 20;

    // field widths
    localparam int ObjW    = 17;
    localparam int AmbW    = 15;
    localparam int DriftW  = 16;
    localparam int StatusW = 2;
    localparam int OffW    = 11;
    localparam int ThrW    = 10;
    localparam int LimW    = 11;

    // derived storage widths
    localparam int SumW   = ObjW + $clog2(WINDOW);
    localparam int SHeadW = $clog2(WINDOW);
    localparam int SCntW  = $clog2(WINDOW + 1);
    localparam int AHeadW = (LAG > 1) ? $clog2(LAG) : 1;
    localparam int ACntW  = $clog2(LAG + 1);

    // divider step counter, counts down one quotient bit per cycle
    localparam int DivStepW = $clog2(SumW + 1);

    // valid object sample range, hundredths of a degree
    localparam logic signed [ObjW-1:0] ObjMin = -17'sd2000;
    localparam logic signed [ObjW-1:0] ObjMax = 17'sd38000;

    // reset values of the settings
    localparam logic signed [AmbW-1:0] AmbRefReset = 15'sd2300;
    localparam logic signed [OffW-1:0] OffReset    = 11'sd0;
    localparam logic [ThrW-1:0]        ThrReset    = 10'd10;
    localparam logic [LimW-1:0]        LimReset    = 11'd100;

    // configuration port
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 15;

    localparam logic [CfgIdxW-1:0] CFG_AMB_REF   = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_CORE_OFF  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_THRESHOLD = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_DRIFT_LIM = 3'd3;

    // status codes
    localparam logic [StatusW-1:0] ST_INVALID  = 2'd0;
    localparam logic [StatusW-1:0] ST_SETTLING = 2'd1;
    localparam logic [StatusW-1:0] ST_SETTLED  = 2'd2;
    localparam logic [StatusW-1:0] ST_DRIFT    = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SUM,
        S_DIV,
        S_FIN
    } t_state;

endpackage

// ----- rtl/thermal_settling_detector_core.sv -----
// thermal settling detector: each input beat carries one object and one ambient sample in
// hundredths of a degree C. a sample with a failed read or outside -20..380 C returns a beat
// with status invalid and all other fields zero, and leaves the history untouched. a good
// sample enters a 60 deep window (running sum), the truncated window average enters a 20 deep
// lag ring, and once that ring is full the slope against the average 20 samples back decides
// settled (|slope| <= threshold); settled with |ambient - reference| > limit reports drift.
// core estimate is average plus offset. the average comes from a restoring divider that
// makes one quotient bit per cycle; ready returns once the result register is free, and for
// a good sample only after the divide. one item is in work at a time; the result sits in an
// output register so the next beat can be accepted while it waits. the user must write settings
// through the cfg port only while the block is idle; the block itself does not enforce it.
module thermal_settling_detector_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration writes
    input  logic                                   i_cfg_we,
    input  logic [tsd_pkg::CfgIdxW-1:0]            i_cfg_index,
    input  logic [tsd_pkg::CfgDataW-1:0]           i_cfg_data,
    // sample channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [tsd_pkg::ObjW-1:0]        i_obj_temp,
    input  logic                                   i_obj_ok,
    input  logic signed [tsd_pkg::AmbW-1:0]        i_ambient_temp,
    // result channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [tsd_pkg::StatusW-1:0]            o_status,
    output logic signed [tsd_pkg::ObjW-1:0]        o_window_average,
    output logic signed [tsd_pkg::ObjW-1:0]        o_slope,
    output logic                                   o_slope_valid,
    output logic signed [tsd_pkg::DriftW-1:0]      o_ambient_drift,
    output logic signed [tsd_pkg::ObjW-1:0]        o_core_estimate
);

    // sequencer
    tsd_pkg::t_state r_state;
    tsd_pkg::t_state n_state;

    // settings
    logic signed [tsd_pkg::AmbW-1:0]   r_amb_ref;
    logic signed [tsd_pkg::OffW-1:0]   r_core_off;
    logic [tsd_pkg::ThrW-1:0]          r_threshold;
    logic [tsd_pkg::LimW-1:0]          r_drift_lim;

    // captured beat
    logic signed [tsd_pkg::ObjW-1:0]   r_obj;
    logic signed [tsd_pkg::AmbW-1:0]   r_amb;
    logic                              r_bad;

    // window and lag ring bookkeeping
    logic [tsd_pkg::SHeadW-1:0]        r_s_head;
    logic [tsd_pkg::SCntW-1:0]         r_s_count;
    logic signed [tsd_pkg::SumW-1:0]   r_s_sum;
    logic [tsd_pkg::AHeadW-1:0]        r_a_head;
    logic [tsd_pkg::ACntW-1:0]         r_a_count;

    // result register
    logic                              r_out_valid;
    logic [tsd_pkg::StatusW-1:0]       r_status;
    logic signed [tsd_pkg::ObjW-1:0]   r_avg;
    logic signed [tsd_pkg::ObjW-1:0]   r_slope;
    logic                              r_slope_valid;
    logic signed [tsd_pkg::DriftW-1:0] r_drift;
    logic signed [tsd_pkg::ObjW-1:0]   r_core;

    // sequencer controls
    logic s_in_ready;
    logic s_div_start;
    logic s_s_we;
    logic s_a_we;
    logic s_out_load;
    logic s_out_free;

    // datapath
    logic                              s_accept;
    logic                              s_in_bad;
    logic [tsd_pkg::ObjW-1:0]          s_s_rdata;
    logic [tsd_pkg::ObjW-1:0]          s_a_rdata;
    logic                              s_s_full;
    logic signed [tsd_pkg::SumW-1:0]   s_old;
    logic signed [tsd_pkg::SumW-1:0]   s_sum_new;
    logic [tsd_pkg::SCntW-1:0]         s_count_new;
    logic                              s_div_done;
    logic signed [tsd_pkg::SumW-1:0]   s_quot;
    logic signed [tsd_pkg::ObjW-1:0]   s_avg;
    logic                              s_slope_valid;
    logic signed [tsd_pkg::ObjW-1:0]   s_slope_raw;
    logic signed [tsd_pkg::ObjW-1:0]   s_slope;
    logic [tsd_pkg::ObjW-1:0]          s_slope_mag;
    logic signed [tsd_pkg::DriftW-1:0] s_drift;
    logic [tsd_pkg::DriftW-1:0]        s_drift_mag;
    logic signed [tsd_pkg::ObjW-1:0]   s_core;
    logic                              s_settled;
    logic                              s_warn;
    logic [tsd_pkg::StatusW-1:0]       s_status;

    assign s_accept   = i_in_valid && s_in_ready;
    assign s_out_free = !r_out_valid || i_out_ready;
    assign s_in_bad   = !i_obj_ok || (i_obj_temp < tsd_pkg::ObjMin)
                        || (i_obj_temp > tsd_pkg::ObjMax);

    // ---------------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            tsd_pkg::S_IDLE: begin
                if (s_accept) begin
                    n_state = s_in_bad ? tsd_pkg::S_FIN : tsd_pkg::S_READ;
                end
            end
            tsd_pkg::S_READ: begin
                n_state = tsd_pkg::S_SUM;
            end
            tsd_pkg::S_SUM: begin
                n_state = tsd_pkg::S_DIV;
            end
            tsd_pkg::S_DIV: begin
                if (s_div_done) begin
                    n_state = tsd_pkg::S_FIN;
                end
            end
            tsd_pkg::S_FIN: begin
                if (s_out_free) begin
                    n_state = tsd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tsd_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // sequencer outputs
    // ---------------------------------------------------------------------
    always_comb begin
        s_in_ready  = 1'b0;
        s_div_start = 1'b0;
        s_s_we      = 1'b0;
        s_a_we      = 1'b0;
        s_out_load  = 1'b0;
        case (r_state)
            tsd_pkg::S_IDLE: begin
                s_in_ready = 1'b1;
            end
            tsd_pkg::S_SUM: begin
                // old window entry is on the ram output now
                s_s_we      = 1'b1;
                s_div_start = 1'b1;
            end
            tsd_pkg::S_FIN: begin
                // hold here until the result register can take the beat
                s_out_load = s_out_free;
                s_a_we     = s_out_free && !r_bad;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------------
    // settings
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amb_ref   <= tsd_pkg::AmbRefReset;
            r_core_off  <= tsd_pkg::OffReset;
            r_threshold <= tsd_pkg::ThrReset;
            r_drift_lim <= tsd_pkg::LimReset;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tsd_pkg::CFG_AMB_REF:   r_amb_ref   <= i_cfg_data[tsd_pkg::AmbW-1:0];
                tsd_pkg::CFG_CORE_OFF:  r_core_off  <= i_cfg_data[tsd_pkg::OffW-1:0];
                tsd_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data[tsd_pkg::ThrW-1:0];
                tsd_pkg::CFG_DRIFT_LIM: r_drift_lim <= i_cfg_data[tsd_pkg::LimW-1:0];
                default: begin
                end
            endcase
        end
    end

    // capture of the accepted beat
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_obj <= i_obj_temp;
            r_amb <= i_ambient_temp;
            r_bad <= s_in_bad;
        end
    end

    // ---------------------------------------------------------------------
    // sample window: ring in ram, running sum in a register
    // ---------------------------------------------------------------------
    tsd_ram #(
        .WIDTH (tsd_pkg::ObjW),
        .DEPTH (tsd_pkg::WINDOW)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (s_s_we),
        .i_waddr (r_s_head),
        .i_wdata (r_obj),
        .i_raddr (r_s_head),
        .o_rdata (s_s_rdata)
    );

    assign s_s_full    = r_s_count == tsd_pkg::SCntW'(tsd_pkg::WINDOW);
    // oldest sample drops out once the window is full
    assign s_old       = s_s_full ? tsd_pkg::SumW'($signed(s_s_rdata)) : '0;
    assign s_sum_new   = r_s_sum - s_old + tsd_pkg::SumW'(r_obj);
    assign s_count_new = s_s_full ? r_s_count : r_s_count + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_head  <= '0;
            r_s_count <= '0;
            r_s_sum   <= '0;
        end else if (s_s_we) begin
            r_s_head  <= (r_s_head == tsd_pkg::SHeadW'(tsd_pkg::WINDOW - 1))
                         ? '0 : r_s_head + 1'b1;
            r_s_count <= s_count_new;
            r_s_sum   <= s_sum_new;
        end
    end

    // window average: sum over count, one quotient bit per cycle
    tsd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_div_start),
        .i_dividend (s_sum_new),
        .i_divisor  (s_count_new),
        .o_done     (s_div_done),
        .o_quotient (s_quot)
    );

    // ---------------------------------------------------------------------
    // lag ring of averages
    // ---------------------------------------------------------------------
    tsd_ram #(
        .WIDTH (tsd_pkg::ObjW),
        .DEPTH (tsd_pkg::LAG)
    ) u_average_ram (
        .i_clk   (i_clk),
        .i_we    (s_a_we),
        .i_waddr (r_a_head),
        .i_wdata (s_avg),
        .i_raddr (r_a_head),
        .o_rdata (s_a_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_head  <= '0;
            r_a_count <= '0;
        end else if (s_a_we) begin
            r_a_head  <= (r_a_head == tsd_pkg::AHeadW'(tsd_pkg::LAG - 1))
                         ? '0 : r_a_head + 1'b1;
            if (!s_slope_valid) begin
                r_a_count <= r_a_count + 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------------
    // result fields
    // ---------------------------------------------------------------------
    assign s_avg         = s_quot[tsd_pkg::ObjW-1:0];
    assign s_slope_valid = r_a_count == tsd_pkg::ACntW'(tsd_pkg::LAG);
    assign s_slope_raw   = s_avg - $signed(s_a_rdata);
    assign s_slope       = s_slope_valid ? s_slope_raw : '0;
    assign s_slope_mag   = s_slope[tsd_pkg::ObjW-1] ? (-s_slope) : s_slope;
    assign s_drift       = tsd_pkg::DriftW'(r_amb) - tsd_pkg::DriftW'(r_amb_ref);
    assign s_drift_mag   = s_drift[tsd_pkg::DriftW-1] ? (-s_drift) : s_drift;
    assign s_core        = s_avg + tsd_pkg::ObjW'(r_core_off);

    assign s_settled = s_slope_valid
                       && (s_slope_mag <= tsd_pkg::ObjW'(r_threshold));
    assign s_warn    = s_drift_mag > tsd_pkg::DriftW'(r_drift_lim);

    always_comb begin
        if (!s_settled) begin
            s_status = tsd_pkg::ST_SETTLING;
        end else if (s_warn) begin
            s_status = tsd_pkg::ST_DRIFT;
        end else begin
            s_status = tsd_pkg::ST_SETTLED;
        end
    end

    // output register, parts the result side from the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_out_load) begin
            if (r_bad) begin
                // rejected sample: status invalid, all else zero
                r_status      <= tsd_pkg::ST_INVALID;
                r_avg         <= '0;
                r_slope       <= '0;
                r_slope_valid <= 1'b0;
                r_drift       <= '0;
                r_core        <= '0;
            end else begin
                r_status      <= s_status;
                r_avg         <= s_avg;
                r_slope       <= s_slope;
                r_slope_valid <= s_slope_valid;
                r_drift       <= s_drift;
                r_core        <= s_core;
            end
        end
    end

    assign o_in_ready       = s_in_ready;
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_window_average = r_avg;
    assign o_slope          = r_slope;
    assign o_slope_valid    = r_slope_valid;
    assign o_ambient_drift  = r_drift;
    assign o_core_estimate  = r_core;

`ifndef ASSERT_OFF
    // one sample in work at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("sample beat accepted while another is in work");

    // window fill never passes the window depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_count <= tsd_pkg::SCntW'(tsd_pkg::WINDOW))
        else $error("window count beyond depth");

    // divider finishes only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_div_done |-> (r_state == tsd_pkg::S_DIV))
        else $error("divider done outside of divide state");

    // a rejected sample leaves the history alone and reports invalid
    a_bad_no_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_out_load && r_bad) |=> (o_status == tsd_pkg::ST_INVALID)
            && $stable(r_s_count) && $stable(r_a_count) && $stable(r_s_sum))
        else $error("rejected sample changed state or status");
`endif

endmodule

// ----- rtl/tsd_ram.sv -----
module tsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/tsd_div.sv -----
module tsd_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [tsd_pkg::SumW-1:0]    i_dividend,
    input  logic [tsd_pkg::SCntW-1:0]          i_divisor,
    output logic                               o_done,
    output logic signed [tsd_pkg::SumW-1:0]    o_quotient
);

    logic                           r_busy;
    logic                           r_done;
    logic [tsd_pkg::DivStepW-1:0]   r_step;
    logic [tsd_pkg::SCntW:0]        r_rem;
    logic [tsd_pkg::SumW-1:0]       r_quo;
    logic [tsd_pkg::SCntW-1:0]      r_div;
    logic                           r_neg;

    logic [tsd_pkg::SumW-1:0]       s_mag;
    logic [tsd_pkg::SCntW:0]        s_shift;
    logic [tsd_pkg::SCntW:0]        s_diff;
    logic                           s_fit;

    // magnitude of the dividend, restoring one bit per cycle
    assign s_mag   = i_dividend[tsd_pkg::SumW-1] ? (-i_dividend) : i_dividend;
    assign s_shift = {r_rem[tsd_pkg::SCntW-1:0], r_quo[tsd_pkg::SumW-1]};
    assign s_diff  = s_shift - {1'b0, r_div};
    assign s_fit   = s_shift >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= tsd_pkg::DivStepW'(tsd_pkg::SumW);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == tsd_pkg::DivStepW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= s_mag;
            r_rem <= '0;
            r_div <= i_divisor;
            r_neg <= i_dividend[tsd_pkg::SumW-1];
        end else if (r_busy) begin
            r_rem <= s_fit ? s_diff : s_shift;
            r_quo <= {r_quo[tsd_pkg::SumW-2:0], s_fit};
        end
    end

    // truncation toward zero: sign goes back on the magnitude quotient
    assign o_quotient = r_neg ? (-$signed(r_quo)) : $signed(r_quo);
    assign o_done     = r_done;

endmodule
